/* rtl/bra_pkg.sv */
package bra_pkg;

    localparam int FIELD_WIDTH = 32;
    localparam int NUM_OUT_WIDTH = 33;
    localparam int OUT_DATA_WIDTH = 72;
    localparam logic [FIELD_WIDTH-1:0] LIMIT_RESET = 32'd65535;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_WB,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_run;
        logic write_back;
        logic mul_init;
        logic mul_run;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic fits;
        logic last;
    } status_t;

endpackage

/* rtl/bra_ctrl.sv */
module bra_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  bra_pkg::status_t   status,
    output bra_pkg::cmd_t      cmd
);

    bra_pkg::state_t state_reg;
    bra_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bra_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = bra_pkg::ST_STEP;
                end
            end
            bra_pkg::ST_STEP:
            begin
                if (status.err)
                begin
                    state_next = bra_pkg::ST_DONE;
                end
                else if (status.fits)
                begin
                    state_next = bra_pkg::ST_DIV;
                end
                else
                begin
                    state_next = bra_pkg::ST_MUL;
                end
            end
            bra_pkg::ST_DIV:
            begin
                if (status.last)
                begin
                    state_next = bra_pkg::ST_WB;
                end
            end
            bra_pkg::ST_WB:
            begin
                state_next = bra_pkg::ST_STEP;
            end
            bra_pkg::ST_MUL:
            begin
                if (status.last)
                begin
                    state_next = bra_pkg::ST_DONE;
                end
            end
            bra_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bra_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            bra_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            bra_pkg::ST_STEP:
            begin
                if (!status.err)
                begin
                    cmd.div_init = status.fits;
                    cmd.mul_init = !status.fits;
                end
            end
            bra_pkg::ST_DIV:
            begin
                cmd.div_run = 1'b1;
            end
            bra_pkg::ST_WB:
            begin
                cmd.write_back = 1'b1;
            end
            bra_pkg::ST_MUL:
            begin
                cmd.mul_run = 1'b1;
            end
            bra_pkg::ST_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

/* rtl/bra_datapath.sv */
module bra_datapath
#(
    parameter int VW = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [bra_pkg::FIELD_WIDTH-1:0]      cfg_wdata,
    input  logic [2*bra_pkg::FIELD_WIDTH-1:0]    in_data,
    input  bra_pkg::cmd_t                        cmd,
    output bra_pkg::status_t                     status,
    output logic [bra_pkg::NUM_OUT_WIDTH-1:0]    out_num,
    output logic [bra_pkg::FIELD_WIDTH-1:0]      out_den,
    output logic                                 out_err
);

    localparam int FW = bra_pkg::FIELD_WIDTH;
    localparam int OW = bra_pkg::NUM_OUT_WIDTH;
    localparam int NW = VW + 1;
    localparam int WW = 2 * VW;
    localparam int CW = $clog2(VW);

    logic [VW-1:0] lim_reg, lim_next;
    logic [NW-1:0] ln_reg, ln_next, hn_reg, hn_next, acc_reg, acc_next;
    logic [VW-1:0] ld_reg, ld_next, hd_reg, hd_next;
    logic [VW-1:0] b_reg, b_next, a_reg, a_next;
    logic [VW-1:0] r1_reg, r1_next, r2_reg, r2_next;
    logic [WW-1:0] d1s_reg, d1s_next, d2s_reg, d2s_next, xs_reg, xs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          dir_reg, dir_next, err_reg, err_next;
    logic [OW-1:0] onum_reg, onum_next;
    logic [FW-1:0] oden_reg, oden_next;
    logic          oerr_reg, oerr_next;

    logic [VW-1:0] in_num, in_den;
    logic [VW-1:0] r1_init, r2_init, d1_init, d2_init;
    logic [NW-1:0] x_init, acc_init;
    logic          dir_sel, div_ok, pick_lo;
    logic [NW-1:0] sel_num;
    logic [VW-1:0] sel_den;

    assign in_num = in_data[VW-1:0];
    assign in_den = in_data[FW +: VW];

    assign dir_sel = b_reg >= a_reg;
    assign div_ok  = ({{VW{1'b0}}, r1_reg} >= d1s_reg) && ({{VW{1'b0}}, r2_reg} >= d2s_reg);
    assign pick_lo = err_reg || (d1s_reg <= d2s_reg);
    assign sel_num = pick_lo ? ln_reg : hn_reg;
    assign sel_den = pick_lo ? ld_reg : hd_reg;

    assign status.err  = err_reg;
    assign status.fits = ({1'b0, ld_reg} + {1'b0, hd_reg}) <= {1'b0, lim_reg};
    assign status.last = (cnt_reg == '0);

    assign out_num = onum_reg;
    assign out_den = oden_reg;
    assign out_err = oerr_reg;

    always_comb
    begin
        if (dir_sel)
        begin
            r1_init  = b_reg;
            d1_init  = a_reg;
            r2_init  = lim_reg - ld_reg;
            d2_init  = hd_reg;
            x_init   = hn_reg;
            acc_init = ln_reg;
        end
        else
        begin
            r1_init  = lim_reg - hd_reg;
            d1_init  = ld_reg;
            r2_init  = a_reg - VW'(1);
            d2_init  = b_reg;
            x_init   = ln_reg;
            acc_init = hn_reg;
        end
    end

    always_comb
    begin
        lim_next  = lim_reg;
        ln_next   = ln_reg;
        hn_next   = hn_reg;
        acc_next  = acc_reg;
        ld_next   = ld_reg;
        hd_next   = hd_reg;
        b_next    = b_reg;
        a_next    = a_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        d1s_next  = d1s_reg;
        d2s_next  = d2s_reg;
        xs_next   = xs_reg;
        cnt_next  = cnt_reg;
        dir_next  = dir_reg;
        err_next  = err_reg;
        onum_next = onum_reg;
        oden_next = oden_reg;
        oerr_next = oerr_reg;

        if (cfg_wen)
        begin
            lim_next = cfg_wdata[VW-1:0];
        end

        if (cmd.load)
        begin
            b_next   = in_num;
            a_next   = in_den;
            err_next = (in_den == '0);
            ln_next  = NW'(0);
            ld_next  = VW'(1);
            hn_next  = NW'(1);
            hd_next  = VW'(0);
        end

        if (cmd.div_init)
        begin
            dir_next = dir_sel;
            r1_next  = r1_init;
            r2_next  = r2_init;
            d1s_next = {{VW{1'b0}}, d1_init} << (VW - 1);
            d2s_next = {{VW{1'b0}}, d2_init} << (VW - 1);
            xs_next  = {{(WW - NW){1'b0}}, x_init} << (VW - 1);
            acc_next = acc_init;
            cnt_next = CW'(VW - 1);
        end

        if (cmd.div_run)
        begin
            if (div_ok)
            begin
                r1_next  = r1_reg - d1s_reg[VW-1:0];
                r2_next  = r2_reg - d2s_reg[VW-1:0];
                acc_next = acc_reg + xs_reg[NW-1:0];
            end
            d1s_next = d1s_reg >> 1;
            d2s_next = d2s_reg >> 1;
            xs_next  = xs_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.write_back)
        begin
            if (dir_reg)
            begin
                b_next  = r1_reg;
                ld_next = lim_reg - r2_reg;
                ln_next = acc_reg;
            end
            else
            begin
                hd_next = lim_reg - r1_reg;
                a_next  = r2_reg + VW'(1);
                hn_next = acc_reg;
            end
        end

        if (cmd.mul_init)
        begin
            d1s_next = '0;
            d2s_next = '0;
            cnt_next = CW'(VW - 1);
        end

        if (cmd.mul_run)
        begin
            d1s_next = (d1s_reg << 1) + (hd_reg[cnt_reg] ? {{VW{1'b0}}, b_reg} : {WW{1'b0}});
            d2s_next = (d2s_reg << 1) + (ld_reg[cnt_reg] ? {{VW{1'b0}}, a_reg} : {WW{1'b0}});
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.load_out)
        begin
            onum_next = OW'(sel_num);
            oden_next = FW'(sel_den);
            oerr_next = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= bra_pkg::LIMIT_RESET[VW-1:0];
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ln_reg   <= ln_next;
        hn_reg   <= hn_next;
        acc_reg  <= acc_next;
        ld_reg   <= ld_next;
        hd_reg   <= hd_next;
        b_reg    <= b_next;
        a_reg    <= a_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        d1s_reg  <= d1s_next;
        d2s_reg  <= d2s_next;
        xs_reg   <= xs_next;
        cnt_reg  <= cnt_next;
        dir_reg  <= dir_next;
        err_reg  <= err_next;
        onum_reg <= onum_next;
        oden_reg <= oden_next;
        oerr_reg <= oerr_next;
    end

    // A write-back must follow the final quotient bit of a division.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_back |-> $past(cmd.div_run) && $past(status.last))
        else $error("write-back without a completed division");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (ld_reg == VW'(1)) && (hd_reg == '0) && (hn_reg == NW'(1)))
        else $error("bounds not set to 0/1 and 1/0 after accepting a word");

    // The upper bound always lies strictly above the target.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_run |-> (a_reg != '0))
        else $error("upper bound reached the target");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !err_reg && (lim_reg != '0)) |->
            (sel_den <= lim_reg) && (sel_den != '0))
        else $error("result denominator outside the limit");

endmodule

/* rtl/best_rational_approximation_core.sv */
// Returns the fraction nearest to p/q whose denominator does not exceed the configured
// limit, walking the Stern-Brocot tree with runs of equal moves taken as one step; a tie
// goes to the lower bound and a zero denominator gives 0/1 with the error flag set. One
// word is processed at a time, and the next is accepted while a finished result waits in
// the output register. W is the effective value width (32 by default), and the number of
// runs in the walk is roughly the number of continued-fraction terms of p/q below the
// limit (at most about 2*W). Each run costs one pass of the bit-serial
// divide-and-accumulate unit, one quotient bit per cycle, and the final choice costs one
// bit-serial pass of two cross products. A zero denominator skips both and goes straight
// to the output.
module best_rational_approximation_core
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [31:0]  cfg_wdata,       // denominator_limit
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,    // target_numerator, target_denominator
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,    // approx_numerator, approx_denominator, zero fill
    output logic         m_axis_tuser     // input_error
);

    localparam int VW = (VALUE_WIDTH < bra_pkg::FIELD_WIDTH) ? VALUE_WIDTH
                                                              : bra_pkg::FIELD_WIDTH;
    localparam int PAD = bra_pkg::OUT_DATA_WIDTH - bra_pkg::NUM_OUT_WIDTH
                         - bra_pkg::FIELD_WIDTH;

    bra_pkg::cmd_t                      cmd;
    bra_pkg::status_t                   status;
    logic [bra_pkg::NUM_OUT_WIDTH-1:0]  out_num;
    logic [bra_pkg::FIELD_WIDTH-1:0]    out_den;
    logic                               out_err;

    bra_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bra_datapath #(
        .VW (VW)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_num   (out_num),
        .out_den   (out_den),
        .out_err   (out_err)
    );

    assign m_axis_tdata = {{PAD{1'b0}}, out_den, out_num};
    assign m_axis_tuser = out_err;

endmodule
